// ----- rtl/rwda_pkg.sv -----
// ----------------------------------------------------------------------------
// rwda_pkg
// shared codes and field positions for the radiation window dose alarm
// ----------------------------------------------------------------------------
package rwda_pkg;

    // alarm levels and sound codes
    localparam logic [1:0] LVL_NONE    = 2'd0;
    localparam logic [1:0] LVL_WARNING = 2'd1;
    localparam logic [1:0] LVL_DANGER  = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_WARNING = 2'd0;
    localparam logic [1:0] REG_DANGER  = 2'd1;
    localparam logic [1:0] REG_PERIOD  = 2'd2;
    localparam logic [1:0] REG_KICK    = 2'd3;

    // reset values of the registers
    localparam logic [13:0] WARNING_RST = 14'd85;
    localparam logic [13:0] DANGER_RST  = 14'd170;
    localparam logic [15:0] PERIOD_RST  = 16'd1800;
    localparam logic [7:0]  KICK_RST    = 8'd15;

    // result word layout
    localparam int OUT_WIDTH   = 32;
    localparam int WT_LSB      = 0;
    localparam int SOUND_LSB   = 14;
    localparam int LEVEL_LSB   = 16;
    localparam int KICK_BIT    = 18;
    localparam int TICK_LSB    = 19;
    localparam int PAD_LSB     = 27;

    localparam logic [31:0] WT_MAX = 32'd16383;

endpackage

// ----- rtl/radiation_window_dose_alarm_top.sv -----
// ----------------------------------------------------------------------------
// radiation_window_dose_alarm_top
// per-tick pulse difference, sliding window dose sum and two-level alarm
// ----------------------------------------------------------------------------
// usage
//   s_tdata carries the free-running 32-bit pulse total, one transfer per
//   one-second tick. every input transfer yields exactly one result transfer
//   on m_tdata: window total, sound request, alarm level, pump kick flag and
//   the saturated pulse count of the tick.
//   the window bytes live in a single-port-write, registered-read memory of
//   WINDOW_LENGTH entries. the byte about to be replaced is read in the
//   accept cycle and the new byte written back when the update stage fires,
//   where the running sum and the alarm rule are evaluated.
//   throughput: one item per cycle unless the result stream is stalled;
//   consecutive items touch neighboring slots so no forwarding is needed
//   for WINDOW_LENGTH >= 2.
//   reset clears all control state and the per-entry valid bits, so every
//   window slot reads as zero until written; no clearing pass is needed.
//   when m_tready is low the result register holds, the update stage holds
//   one more item, and s_tready drops once both are full. the user writes
//   registers through apb only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module radiation_window_dose_alarm_top
    import rwda_pkg::*;
#(
    parameter int WINDOW_LENGTH = 40
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] total_pulses
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [13:0] window_total, [15:14] sound_request,
                                   // [17:16] alarm_state, [18] pump_kick,
                                   // [26:19] tick_pulses, [31:27] zero
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int TW = $clog2(WINDOW_LENGTH * 255 + 1);

    // configuration registers
    logic [13:0] warning_reg;
    logic [13:0] danger_reg;
    logic [15:0] period_reg;
    logic [7:0]  kick_thr_reg;

    // accept-side state
    logic [31:0]   prev_total_reg;
    logic [SW-1:0] slot_reg;

    // window memory and its valid bits
    logic [7:0]               window_mem [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] valid_reg;

    // update stage
    logic          s1_valid_reg;
    logic [7:0]    s1_tick_reg;
    logic          s1_kick_reg;
    logic [SW-1:0] s1_slot_reg;
    logic [7:0]    s1_old_reg;
    logic          s1_old_valid_reg;

    // running state of the alarm
    logic [TW-1:0] run_total_reg;
    logic [15:0]   countdown_reg;
    logic [1:0]    level_reg;

    // result register
    logic                 out_valid_reg;
    logic [OUT_WIDTH-1:0] out_data_reg;

    // handshake
    logic stall;
    logic in_xfer;
    logic s1_fire;
    logic cfg_wr;

    // accept-side datapath
    logic [31:0]   diff;
    logic          kick;
    logic [7:0]    tick_sat;
    logic [SW-1:0] slot_next;

    // update datapath
    logic [7:0]    old_byte;
    logic [TW-1:0] total_next;
    logic          over_danger;
    logic          over_warning;
    logic [15:0]   cnt_armed;
    logic [1:0]    lvl_armed;
    logic [1:0]    sound;
    logic [15:0]   countdown_next;
    logic [1:0]    level_next;
    logic [13:0]   wt_out;

    assign stall    = out_valid_reg && !m_tready;
    assign s_tready = !s1_valid_reg || !stall;
    assign in_xfer  = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && !stall;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WARNING: prdata = {18'd0, warning_reg};
            REG_DANGER:  prdata = {18'd0, danger_reg};
            REG_PERIOD:  prdata = {16'd0, period_reg};
            REG_KICK:    prdata = {24'd0, kick_thr_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warning_reg  <= WARNING_RST;
            danger_reg   <= DANGER_RST;
            period_reg   <= PERIOD_RST;
            kick_thr_reg <= KICK_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WARNING: warning_reg  <= pwdata[13:0];
                REG_DANGER:  danger_reg   <= pwdata[13:0];
                REG_PERIOD:  period_reg   <= pwdata[15:0];
                REG_KICK:    kick_thr_reg <= pwdata[7:0];
            endcase
        end
    end

    // ---------------- accept stage ----------------
    // modular difference against the last total
    assign diff      = s_tdata - prev_total_reg;
    assign kick      = diff > {24'd0, kick_thr_reg};
    assign tick_sat  = (diff > 32'd255) ? 8'hFF : diff[7:0];
    assign slot_next = (slot_reg == SW'(WINDOW_LENGTH - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_total_reg <= '0;
            slot_reg       <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                prev_total_reg <= s_tdata;
                slot_reg       <= slot_next;
            end
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

    // memory read of the byte being replaced, plus stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_old_reg       <= window_mem[slot_reg];
            s1_old_valid_reg <= valid_reg[slot_reg];
            s1_tick_reg      <= tick_sat;
            s1_kick_reg      <= kick;
            s1_slot_reg      <= slot_reg;
        end
    end

    // write back of the new byte
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            window_mem[s1_slot_reg] <= s1_tick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (s1_fire)
            valid_reg[s1_slot_reg] <= 1'b1;
    end

    // ---------------- update stage ----------------
    // a slot never written reads as zero
    assign old_byte   = s1_old_valid_reg ? s1_old_reg : 8'd0;
    assign total_next = run_total_reg - TW'(old_byte) + TW'(s1_tick_reg);

    assign over_danger  = 32'(total_next) > 32'(danger_reg);
    assign over_warning = 32'(total_next) > 32'(warning_reg);

    // alarm rule: danger first, then warning, then countdown
    always_comb
    begin
        cnt_armed = countdown_reg;
        lvl_armed = level_reg;
        sound     = LVL_NONE;
        priority if (over_danger && (level_reg < LVL_DANGER || countdown_reg == 16'd0))
        begin
            cnt_armed = period_reg;
            lvl_armed = LVL_DANGER;
            sound     = LVL_DANGER;
        end
        else if (over_warning && (level_reg < LVL_WARNING || countdown_reg == 16'd0))
        begin
            cnt_armed = period_reg;
            lvl_armed = LVL_WARNING;
            sound     = LVL_WARNING;
        end

        if (cnt_armed != 16'd0)
        begin
            countdown_next = cnt_armed - 16'd1;
            level_next     = lvl_armed;
        end
        else
        begin
            countdown_next = cnt_armed;
            level_next     = LVL_NONE;
        end
    end

    // reported total saturates, internal sum stays exact
    assign wt_out = (32'(total_next) > WT_MAX) ? WT_MAX[13:0] : 14'(total_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_total_reg <= '0;
            countdown_reg <= '0;
            level_reg     <= LVL_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                run_total_reg <= total_next;
                countdown_reg <= countdown_next;
                level_reg     <= level_next;
            end
            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            out_data_reg <= {5'd0, s1_tick_reg, s1_kick_reg, level_next, sound, wt_out};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- rtl/rwda_checker.sv -----
// ----------------------------------------------------------------------------
// rwda_checker
// port-level checks on the result stream of the dose alarm
// ----------------------------------------------------------------------------
module rwda_checker
    import rwda_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [1:0] sound_f;
    logic [1:0] level_f;
    logic [7:0] tick_f;

    assign sound_f = m_tdata[SOUND_LSB +: 2];
    assign level_f = m_tdata[LEVEL_LSB +: 2];
    assign tick_f  = m_tdata[TICK_LSB +: 8];

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a sound leaves the level at that sound or, with a zero period, cleared
    a_sound_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sound_f != LVL_NONE |-> level_f == sound_f || level_f == LVL_NONE)
        else $error("sound request disagrees with alarm level");

    // a kick needs at least one pulse in the tick
    a_kick_tick: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && tick_f == 8'd0 |-> !m_tdata[KICK_BIT])
        else $error("pump kick without pulses");

    // padding above the fields stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_WIDTH-1:PAD_LSB] == '0)
        else $error("nonzero padding in result");

endmodule

bind radiation_window_dose_alarm_top rwda_checker u_rwda_checker (.*);
